// ----- hw/rtl/gbba_pkg.sv -----
`default_nettype none
package gbba_pkg;

  // default sizes of the bitmap store
  localparam int MAX_GROUPS_DEF = 16;
  localparam int MAX_WORDS_DEF  = 256;

  // field widths
  localparam int CMD_W = 2;
  localparam int BLK_W = 18;
  localparam int GI_W  = 4;
  localparam int WI_W  = 8;
  localparam int WV_W  = 32;
  localparam int FC_W  = 14;
  localparam int STS_W = 2;

  // input tdata layout, lowest bit up
  localparam int BLK_LSB    = 0;
  localparam int GI_LSB     = BLK_LSB + BLK_W;
  localparam int WI_LSB     = GI_LSB + GI_W;
  localparam int WV_LSB     = WI_LSB + WI_W;
  localparam int FC_LSB     = WV_LSB + WV_W;
  localparam int IN_DATA_W  = ((FC_LSB + FC_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((BLK_W + 7) / 8) * 8;

  localparam logic [31:0]      FULL_WORD   = 32'hFFFF_FFFF;
  localparam logic [FC_W-1:0]  COUNTER_MAX = '1;

  // commands
  localparam logic [CMD_W-1:0] CMD_ALLOC     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_WORD = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SET_COUNT = 2'd3;

  // result status
  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_NO_FREE = 2'd1;
  localparam logic [STS_W-1:0] STS_BAD     = 2'd2;

  // configuration registers
  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_GROUP_COUNT      = 2'd0;
  localparam logic [1:0] REG_BLOCKS_PER_GROUP = 2'd1;
  localparam logic [1:0] REG_BITMAP_WORDS     = 2'd2;

  typedef struct packed {
    logic [4:0]  group_count;
    logic [13:0] blocks_per_group;
    logic [8:0]  bitmap_words;
  } cfg_t;

  // index of the lowest clear bit of a word
  function automatic logic [4:0] lowest_clear(input logic [31:0] word);
    logic [31:0] inv;
    logic [31:0] iso;
    logic [4:0]  idx;
    inv = ~word;
    iso = inv & (~inv + 32'd1);
    idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (iso[i]) idx = idx | 5'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/gbba_ram.sv -----
`default_nettype none
module gbba_ram #(
  parameter int AW = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);

  localparam int DEPTH = 1 << AW;

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/gbba_cfg.sv -----
`default_nettype none
module gbba_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [gbba_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  output gbba_pkg::cfg_t                       cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.group_count      <= 5'd16;
      cfg.blocks_per_group <= 14'd8192;
      cfg.bitmap_words     <= 9'd256;
    end else if (wr_en) begin
      unique case (reg_idx)
        gbba_pkg::REG_GROUP_COUNT:      cfg.group_count      <= pwdata[4:0];
        gbba_pkg::REG_BLOCKS_PER_GROUP: cfg.blocks_per_group <= pwdata[13:0];
        gbba_pkg::REG_BITMAP_WORDS:     cfg.bitmap_words     <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      gbba_pkg::REG_GROUP_COUNT:      prdata = 32'(cfg.group_count);
      gbba_pkg::REG_BLOCKS_PER_GROUP: prdata = 32'(cfg.blocks_per_group);
      gbba_pkg::REG_BITMAP_WORDS:     prdata = 32'(cfg.bitmap_words);
      default:                        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/grouped_block_bitmap_allocator_core.sv -----
`default_nettype none
// Grouped first-fit block allocator. Each group owns a bitmap of 32-bit words
// (bit set = used) in one single-port-write, registered-read RAM and a 14-bit
// free counter. Commands arrive one per beat on the s_ stream and each gives
// exactly one result beat on the m_ stream. Allocate walks the groups in order,
// skips a group whose counter is zero and otherwise reads its bitmap words in
// order until one is not full. Free finds the group by repeated subtraction of
// blocks_per_group in one shared subtractor, one group per cycle, then does a
// read-modify-write. Load word and set count write in the idle state and go
// straight to the result state. The RAM read port sets the scan pace of one
// word per cycle. After reset a clearing pass writes zero to every RAM address
// (4096 words by default), during which s_tready stays low; the configuration
// port works throughout.
module grouped_block_bitmap_allocator_core #(
  parameter int MAX_GROUPS          = gbba_pkg::MAX_GROUPS_DEF,
  parameter int MAX_WORDS_PER_GROUP = gbba_pkg::MAX_WORDS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // block_number, group_index, word_index, word_value, free_count, zero pad
  input  wire logic [gbba_pkg::IN_DATA_W-1:0]    s_tdata,
  // command
  input  wire logic [gbba_pkg::CMD_W-1:0]        s_tuser,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // allocated_block, zero pad
  output logic      [gbba_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status
  output logic      [gbba_pkg::STS_W-1:0]        m_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [gbba_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready
);

  localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int WW  = (MAX_WORDS_PER_GROUP > 1) ? $clog2(MAX_WORDS_PER_GROUP) : 1;
  localparam int AW  = GW + WW;
  localparam int GCW = $clog2(MAX_GROUPS + 1);
  localparam int WCW = $clog2(MAX_WORDS_PER_GROUP + 1);
  localparam int BW  = gbba_pkg::BLK_W;
  localparam int FW  = gbba_pkg::FC_W;

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_ALLOC_WR = 3'd3;
  localparam logic [2:0] ST_DIV      = 3'd4;
  localparam logic [2:0] ST_FREE_RD  = 3'd5;
  localparam logic [2:0] ST_RESULT   = 3'd6;

  gbba_pkg::cfg_t cfg;

  gbba_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input fields
  logic [gbba_pkg::CMD_W-1:0] in_cmd;
  logic [BW-1:0]              in_blk;
  logic [31:0]                in_gi;
  logic [31:0]                in_wi;
  logic [31:0]                in_wv;
  logic [FW-1:0]              in_fc;
  logic                       in_gi_ok;
  logic                       in_wi_ok;

  assign in_cmd   = s_tuser;
  assign in_blk   = s_tdata[gbba_pkg::BLK_LSB +: BW];
  assign in_gi    = 32'(s_tdata[gbba_pkg::GI_LSB +: gbba_pkg::GI_W]);
  assign in_wi    = 32'(s_tdata[gbba_pkg::WI_LSB +: gbba_pkg::WI_W]);
  assign in_wv    = s_tdata[gbba_pkg::WV_LSB +: gbba_pkg::WV_W];
  assign in_fc    = s_tdata[gbba_pkg::FC_LSB +: FW];
  assign in_gi_ok = in_gi < 32'(MAX_GROUPS);
  assign in_wi_ok = in_wi < 32'(MAX_WORDS_PER_GROUP);

  // effective configuration
  logic [GCW-1:0] eff_groups;
  logic [WCW-1:0] eff_words;
  logic [BW-1:0]  bpg;

  assign eff_groups = (32'(cfg.group_count) > 32'(MAX_GROUPS)) ?
                      GCW'(MAX_GROUPS) : GCW'(cfg.group_count);
  assign eff_words  = (32'(cfg.bitmap_words) > 32'(MAX_WORDS_PER_GROUP)) ?
                      WCW'(MAX_WORDS_PER_GROUP) : WCW'(cfg.bitmap_words);
  assign bpg        = BW'(cfg.blocks_per_group);

  logic [2:0] state;
  logic [AW-1:0] clr_addr;

  // scan issue side
  logic [GCW-1:0] issue_g;
  logic [WCW-1:0] issue_w;
  logic [BW-1:0]  issue_base;
  // read in flight
  logic          rd_pend;
  logic [GW-1:0] rd_g;
  logic [WW-1:0] rd_w;
  logic [BW-1:0] rd_base;
  // word found
  logic [GW-1:0] hit_g;
  logic [WW-1:0] hit_w;
  logic [BW-1:0] hit_base;
  logic [4:0]    hit_bit;
  logic [31:0]   hit_word;
  // free path
  logic [BW-1:0]  rem;
  logic [GCW-1:0] fg;
  logic [WW-1:0]  fw;
  logic [4:0]     fbit;

  logic [BW-1:0]              res_block;
  logic [gbba_pkg::STS_W-1:0] res_status;

  logic [FW-1:0] cnt [MAX_GROUPS];

  // ram ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  gbba_ram #(.AW(AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  logic          scan_live;
  logic          last_word;
  logic          word_free;
  logic [31:0]   div_w;
  logic [GW-1:0] cnt_ra;
  logic [FW-1:0] cnt_rd;
  logic          free_bit_set;

  assign s_tready     = (state == ST_IDLE);
  assign scan_live    = issue_g < eff_groups;
  assign last_word    = (32'(issue_w) + 32'd1) == 32'(eff_words);
  assign word_free    = rd_pend && (mem_rdata != gbba_pkg::FULL_WORD);
  assign div_w        = 32'(rem[13:5]);
  assign free_bit_set = mem_rdata[fbit];

  // single read port into the counters
  always_comb begin
    unique case (state)
      ST_ALLOC_WR: cnt_ra = hit_g;
      ST_FREE_RD:  cnt_ra = fg[GW-1:0];
      default:     cnt_ra = issue_g[GW-1:0];
    endcase
  end
  assign cnt_rd = cnt[cnt_ra];

  always_comb begin
    if (state == ST_DIV) mem_raddr = {fg[GW-1:0], div_w[WW-1:0]};
    else                 mem_raddr = {issue_g[GW-1:0], issue_w[WW-1:0]};
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {hit_g, hit_w};
    mem_wdata = hit_word | (32'd1 << hit_bit);
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        mem_we    = s_tvalid && (in_cmd == gbba_pkg::CMD_LOAD_WORD) && in_gi_ok && in_wi_ok;
        mem_waddr = {in_gi[GW-1:0], in_wi[WW-1:0]};
        mem_wdata = in_wv;
      end
      ST_ALLOC_WR: begin
        mem_we = 1'b1;
      end
      ST_FREE_RD: begin
        mem_we    = free_bit_set;
        mem_waddr = {fg[GW-1:0], fw};
        mem_wdata = mem_rdata & ~(32'd1 << fbit);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < MAX_GROUPS; i++) cnt[i] <= '0;
    end else begin
      // the result state sets m_tvalid itself
      if (m_tvalid && m_tready && state != ST_RESULT) m_tvalid <= 1'b0;

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) state <= ST_IDLE;
        end

        ST_IDLE: begin
          if (s_tvalid) begin
            res_block <= '0;
            unique case (in_cmd)
              gbba_pkg::CMD_ALLOC: begin
                res_status <= gbba_pkg::STS_OK;
                issue_g    <= '0;
                issue_w    <= '0;
                issue_base <= '0;
                rd_pend    <= 1'b0;
                state      <= ST_SCAN;
              end
              gbba_pkg::CMD_FREE: begin
                if (in_blk == '0 || bpg == '0) begin
                  res_status <= gbba_pkg::STS_BAD;
                  state      <= ST_RESULT;
                end else begin
                  res_status <= gbba_pkg::STS_OK;
                  rem        <= in_blk - BW'(1);
                  fg         <= '0;
                  state      <= ST_DIV;
                end
              end
              gbba_pkg::CMD_LOAD_WORD: begin
                res_status <= gbba_pkg::STS_OK;
                state      <= ST_RESULT;
              end
              gbba_pkg::CMD_SET_COUNT: begin
                res_status <= gbba_pkg::STS_OK;
                if (in_gi_ok) cnt[in_gi[GW-1:0]] <= in_fc;
                state <= ST_RESULT;
              end
              default: begin
                res_status <= gbba_pkg::STS_OK;
                state      <= ST_RESULT;
              end
            endcase
          end
        end

        ST_SCAN: begin
          if (word_free) begin
            hit_g    <= rd_g;
            hit_w    <= rd_w;
            hit_base <= rd_base;
            hit_word <= mem_rdata;
            hit_bit  <= gbba_pkg::lowest_clear(mem_rdata);
            rd_pend  <= 1'b0;
            state    <= ST_ALLOC_WR;
          end else if (!scan_live) begin
            // drain the last read before giving up
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              res_status <= gbba_pkg::STS_NO_FREE;
              state      <= ST_RESULT;
            end
          end else if (cnt_rd == '0 || eff_words == '0) begin
            rd_pend    <= 1'b0;
            issue_g    <= issue_g + GCW'(1);
            issue_w    <= '0;
            issue_base <= issue_base + bpg;
          end else begin
            rd_pend <= 1'b1;
            rd_g    <= issue_g[GW-1:0];
            rd_w    <= issue_w[WW-1:0];
            rd_base <= issue_base;
            if (last_word) begin
              issue_g    <= issue_g + GCW'(1);
              issue_w    <= '0;
              issue_base <= issue_base + bpg;
            end else begin
              issue_w <= issue_w + WCW'(1);
            end
          end
        end

        ST_ALLOC_WR: begin
          cnt[cnt_ra] <= cnt_rd - FW'(1);
          res_block   <= hit_base + BW'({hit_w, 5'b0}) + BW'(hit_bit) + BW'(1);
          state       <= ST_RESULT;
        end

        ST_DIV: begin
          if (!(fg < eff_groups)) begin
            res_status <= gbba_pkg::STS_BAD;
            state      <= ST_RESULT;
          end else if (rem < bpg) begin
            if (div_w >= 32'(eff_words)) begin
              res_status <= gbba_pkg::STS_BAD;
              state      <= ST_RESULT;
            end else begin
              // ram read of this word goes out this cycle
              fw    <= div_w[WW-1:0];
              fbit  <= rem[4:0];
              state <= ST_FREE_RD;
            end
          end else begin
            rem <= rem - bpg;
            fg  <= fg + GCW'(1);
          end
        end

        ST_FREE_RD: begin
          if (!free_bit_set) begin
            res_status <= gbba_pkg::STS_BAD;
          end else if (cnt_rd != gbba_pkg::COUNTER_MAX) begin
            cnt[cnt_ra] <= cnt_rd + FW'(1);
          end
          state <= ST_RESULT;
        end

        ST_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= gbba_pkg::OUT_DATA_W'(res_block);
            m_tuser  <= res_status;
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // a group is only allocated from when its counter was nonzero
  a_alloc_cnt_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ALLOC_WR) |-> (cnt_rd != '0))
    else $error("allocation from a group with zero free count");

  // the chosen bit must have been clear in the word read
  a_alloc_bit_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ALLOC_WR) |-> !hit_word[hit_bit])
    else $error("allocated bit already set");

  // no item is taken while the ram is being cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_tready)
    else $error("input accepted during clearing pass");

  // a failed result never carries a block number
  a_fail_zero_block: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != gbba_pkg::STS_OK) |-> (m_tdata == '0))
    else $error("nonzero block number with error status");

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
module testbench;
  import gbba_pkg::*;

  localparam int MAP_DEPTH    = MAX_GROUPS_DEF * MAX_WORDS_DEF;
  localparam int WORD_BITS    = 32;
  localparam int RUN_LIMIT    = 50_000_000;
  localparam int DRAIN_CYCLES = 200;

  // one command beat; the low fields line up with the s_tdata layout
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [FC_W-1:0]  free_count;
    logic [WV_W-1:0]  word_value;
    logic [WI_W-1:0]  word_index;
    logic [GI_W-1:0]  group_index;
    logic [BLK_W-1:0] block_number;
  } alloc_cmd_t;

  typedef struct packed {
    logic [BLK_W-1:0] block;
    logic [STS_W-1:0] status;
  } alloc_result_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [CMD_W-1:0]      s_tuser  = CMD_ALLOC;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STS_W-1:0]      m_tuser;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [31:0]           pwdata   = '0;
  logic [31:0]           prdata;
  logic                  pready;

  grouped_block_bitmap_allocator_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // allocator shadow state
  logic [31:0]     usage_map [MAP_DEPTH];
  logic [FC_W-1:0] free_left [MAX_GROUPS_DEF];
  cfg_t            cfg_model;

  alloc_result_t expected_results[$];
  int unsigned   mismatches    = 0;
  int unsigned   send_idle_pct = 11;
  int unsigned   recv_idle_pct = 52;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic int unsigned groups_in_use();
    return (cfg_model.group_count > MAX_GROUPS_DEF) ? MAX_GROUPS_DEF : cfg_model.group_count;
  endfunction

  function automatic int unsigned words_in_use();
    return (cfg_model.bitmap_words > MAX_WORDS_DEF) ? MAX_WORDS_DEF : cfg_model.bitmap_words;
  endfunction

  function automatic alloc_result_t predict_outcome(input alloc_cmd_t c);
    alloc_result_t r;
    int unsigned   ng, nw, g, w, b, off, rel, slot;
    bit            found;
    r.block  = '0;
    r.status = STS_OK;
    ng = groups_in_use();
    nw = words_in_use();
    case (c.cmd)
      CMD_ALLOC: begin
        r.status = STS_NO_FREE;
        found = 1'b0;
        for (g = 0; g < ng && !found; g++) begin
          if (free_left[g] != 0) begin
            for (w = 0; w < nw && !found; w++) begin
              slot = g * MAX_WORDS_DEF + w;
              if (usage_map[slot] != FULL_WORD) begin
                for (b = 0; b < WORD_BITS; b++) begin
                  if (!usage_map[slot][b]) break;
                end
                usage_map[slot][b] = 1'b1;
                free_left[g] = free_left[g] - 1'b1;
                r.block  = BLK_W'(g * cfg_model.blocks_per_group + w * WORD_BITS + b + 1);
                r.status = STS_OK;
                found = 1'b1;
              end
            end
          end
        end
      end
      CMD_FREE: begin
        r.status = STS_BAD;
        if (c.block_number != 0 && cfg_model.blocks_per_group != 0) begin
          off = c.block_number - 1;
          g = off / cfg_model.blocks_per_group;
          if (g < ng) begin
            rel = off - g * cfg_model.blocks_per_group;
            w = rel / WORD_BITS;
            b = rel % WORD_BITS;
            slot = g * MAX_WORDS_DEF + w;
            if (w < nw && usage_map[slot][b]) begin
              usage_map[slot][b] = 1'b0;
              if (free_left[g] != COUNTER_MAX) free_left[g] = free_left[g] + 1'b1;
              r.status = STS_OK;
            end
          end
        end
      end
      CMD_LOAD_WORD: usage_map[c.group_index * MAX_WORDS_DEF + c.word_index] = c.word_value;
      default: free_left[c.group_index] = c.free_count;
    endcase
    return r;
  endfunction

  function automatic alloc_cmd_t make_cmd(input logic [CMD_W-1:0] cmd,
                                          input logic [BLK_W-1:0] blk,
                                          input logic [GI_W-1:0] gi,
                                          input logic [WI_W-1:0] wi,
                                          input logic [WV_W-1:0] wv,
                                          input logic [FC_W-1:0] fc);
    alloc_cmd_t c;
    c.cmd          = cmd;
    c.block_number = blk;
    c.group_index  = gi;
    c.word_index   = wi;
    c.word_value   = wv;
    c.free_count   = fc;
    return c;
  endfunction

  // mostly well-formed traffic: frees aim at used blocks, loads at scanned words
  function automatic alloc_cmd_t random_cmd();
    alloc_cmd_t  c;
    int unsigned ng, nw, g, w, b, roll, tries;
    c.cmd          = CMD_ALLOC;
    c.block_number = BLK_W'($urandom);
    c.group_index  = GI_W'($urandom);
    c.word_index   = WI_W'($urandom);
    c.word_value   = $urandom;
    c.free_count   = FC_W'($urandom);
    ng = (groups_in_use() == 0) ? 1 : groups_in_use();
    nw = (words_in_use() == 0) ? 1 : words_in_use();
    roll = $urandom_range(99);
    g = $urandom_range(ng - 1);
    w = $urandom_range(1) ? $urandom_range(nw - 1) : $urandom_range((nw > 4) ? 3 : nw - 1);
    if (roll < 40) begin
      c.cmd = CMD_ALLOC;
    end else if (roll < 65) begin
      c.cmd = CMD_FREE;
      b = $urandom_range(WORD_BITS - 1);
      for (tries = 0; tries < WORD_BITS && !usage_map[g * MAX_WORDS_DEF + w][b]; tries++)
        b = (b + 1) % WORD_BITS;
      c.block_number = BLK_W'(g * cfg_model.blocks_per_group + w * WORD_BITS + b + 1);
    end else if (roll < 70) begin
      c.cmd = CMD_FREE;
      if ($urandom_range(1))
        c.block_number = BLK_W'($urandom_range(ng * cfg_model.blocks_per_group + 1));
    end else if (roll < 85) begin
      c.cmd = CMD_LOAD_WORD;
      if ($urandom_range(3) != 0) begin
        c.group_index = GI_W'(g);
        c.word_index  = WI_W'(w);
      end
      case ($urandom_range(3))
        0: c.word_value = FULL_WORD;
        1: c.word_value = '0;
        default: c.word_value = $urandom;
      endcase
    end else begin
      c.cmd = CMD_SET_COUNT;
      if ($urandom_range(3) != 0) c.group_index = GI_W'(g);
      if ($urandom_range(7) != 0) c.free_count = FC_W'($urandom_range(40));
    end
    return c;
  endfunction

  task automatic send_item(input alloc_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.cmd;
    s_tdata  <= IN_DATA_W'({c.free_count, c.word_value, c.word_index,
                            c.group_index, c.block_number});
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_outcome(c));
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_GROUP_COUNT:      cfg_model.group_count      = val[4:0];
      REG_BLOCKS_PER_GROUP: cfg_model.blocks_per_group = val[13:0];
      REG_BITMAP_WORDS:     cfg_model.bitmap_words     = val[8:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input int unsigned groups, input int unsigned bpg,
                              input int unsigned words);
    write_reg(REG_GROUP_COUNT, groups);
    write_reg(REG_BLOCKS_PER_GROUP, bpg);
    write_reg(REG_BITMAP_WORDS, words);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_item(random_cmd());
    settle();
  endtask

  // reset geometry: 16 groups of 8192 blocks, 256 words each
  task automatic test_directed_cases();
    send_idle_pct = 11;
    recv_idle_pct = 52;
    send_item(make_cmd(CMD_ALLOC, '0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_FREE, 18'd0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_FREE, 18'd1, '0, '0, '0, '0));
    send_item(make_cmd(CMD_SET_COUNT, '1, 4'd0, '1, '1, 14'd2));
    send_item(make_cmd(CMD_ALLOC, '0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_ALLOC, '0, '0, '0, '0, '0));
    // counter of group 0 is used up here
    send_item(make_cmd(CMD_ALLOC, '0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_LOAD_WORD, '0, 4'd0, 8'd0, FULL_WORD, '0));
    send_item(make_cmd(CMD_SET_COUNT, '0, 4'd0, '0, '0, 14'd5));
    send_item(make_cmd(CMD_LOAD_WORD, '0, 4'd0, 8'd1, 32'h7FFF_FFFF, '0));
    send_item(make_cmd(CMD_ALLOC, '0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_ALLOC, '0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_SET_COUNT, '0, 4'd15, '0, '0, COUNTER_MAX));
    send_item(make_cmd(CMD_LOAD_WORD, '0, 4'd15, 8'd255, FULL_WORD, '0));
    // last block of the last group; counter already saturated
    send_item(make_cmd(CMD_FREE, 18'd131072, '0, '0, '0, '0));
    send_item(make_cmd(CMD_FREE, 18'd122881, '0, '0, '0, '0));
    send_item(make_cmd(CMD_FREE, 18'd131073, '0, '0, '0, '0));
    send_item(make_cmd(CMD_FREE, '1, '1, '1, '1, '1));
    send_item(make_cmd(CMD_LOAD_WORD, 18'h2AAAA, 4'd10, 8'hAA, 32'hAAAA_AAAA, 14'h2AAA));
    send_item(make_cmd(CMD_LOAD_WORD, 18'h15555, 4'd5, 8'h55, 32'h5555_5555, 14'h1555));
    send_item(make_cmd(CMD_SET_COUNT, '0, 4'd10, '0, '0, 14'h2AAA));
    send_item(make_cmd(CMD_SET_COUNT, '0, 4'd5, '0, '0, 14'h1555));
    send_item(make_cmd(CMD_ALLOC, '0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_FREE, 18'd64, '0, '0, '0, '0));
    settle();
  endtask

  task automatic test_random_small_groups();
    send_idle_pct = 11;
    recv_idle_pct = 52;
    set_geometry(4, 64, 2);
    run_random(360);
  endtask

  task automatic test_random_many_groups();
    send_idle_pct = 52;
    recv_idle_pct = 11;
    set_geometry(16, 32, 1);
    run_random(360);
  endtask

  task automatic test_config_extremes();
    send_idle_pct = 52;
    recv_idle_pct = 11;
    // no group scanned
    write_reg(REG_GROUP_COUNT, 0);
    send_item(make_cmd(CMD_ALLOC, '0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_FREE, 18'd1, '0, '0, '0, '0));
    settle();
    // oversized group and word counts saturate
    set_geometry(31, 16383, 511);
    send_item(make_cmd(CMD_SET_COUNT, '0, 4'd15, '0, '0, 14'd3));
    send_item(make_cmd(CMD_LOAD_WORD, '0, 4'd15, 8'd255, 32'h7FFF_FFFF, '0));
    send_item(make_cmd(CMD_ALLOC, '0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_FREE, 18'd253937, '0, '0, '0, '0));
    send_item(make_cmd(CMD_FREE, 18'd253936, '0, '0, '0, '0));
    settle();
    write_reg(REG_BLOCKS_PER_GROUP, 0);
    send_item(make_cmd(CMD_ALLOC, '0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_FREE, 18'd5, '0, '0, '0, '0));
    settle();
    write_reg(REG_BITMAP_WORDS, 0);
    send_item(make_cmd(CMD_ALLOC, '0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_FREE, 18'd1, '0, '0, '0, '0));
    settle();
    // counter set but the only scanned word is full
    set_geometry(1, 32, 1);
    send_item(make_cmd(CMD_SET_COUNT, '0, 4'd0, '0, '0, 14'd4));
    send_item(make_cmd(CMD_LOAD_WORD, '0, 4'd0, 8'd0, FULL_WORD, '0));
    send_item(make_cmd(CMD_ALLOC, '0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_LOAD_WORD, '0, 4'd0, 8'd0, 32'd0, '0));
    send_item(make_cmd(CMD_ALLOC, '0, '0, '0, '0, '0));
    send_item(make_cmd(CMD_FREE, 18'd33, '0, '0, '0, '0));
    settle();
  endtask

  task automatic test_random_wide_groups();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_geometry(2, 8192, 256);
    run_random(360);
  endtask

  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with none expected, block %0d status %0d",
                 $time, m_tdata, m_tuser);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata !== OUT_DATA_W'(want.block)) begin
          mismatches++;
          $display("%0t: allocated_block expected %0d, got %0d", $time, want.block, m_tdata);
        end
        if (m_tuser !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d, got %0d", $time, want.status, m_tuser);
        end
      end
    end
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    foreach (usage_map[i]) usage_map[i] = '0;
    foreach (free_left[i]) free_left[i] = '0;
    cfg_model.group_count      = 5'd16;
    cfg_model.blocks_per_group = 14'd8192;
    cfg_model.bitmap_words     = 9'd256;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_small_groups();
    test_random_many_groups();
    test_config_extremes();
    test_random_wide_groups();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
